>>> hdl/qot_pkg.sv
`timescale 1ns / 1ps
package qot_pkg;

	localparam logic [31:0] MPC_RESET = 32'd658842;
	localparam logic [31:0] APC_RESET = 32'd524288;
	localparam logic [31:0] CORDIC_GAIN = 32'd652032874;

	localparam logic CFG_MPC = 1'b0;
	localparam logic CFG_APC = 1'b1;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_PREP,
		BK_ROT,
		BK_DONE
	} bk_state_t;

	// one classified step handed from front to back
	typedef struct packed {
		logic        tick;
		logic [31:0] dl;
		logic [31:0] dr;
		logic [31:0] lc;
		logic [31:0] rc;
	} qot_item_t;

	function automatic logic [31:0] atan_lut(input logic [4:0] i);
		logic [31:0] r;
		unique case (i)
			5'd0: r = 32'd536870912;
			5'd1: r = 32'd316933406;
			5'd2: r = 32'd167458907;
			5'd3: r = 32'd85004756;
			5'd4: r = 32'd42667331;
			5'd5: r = 32'd21354465;
			5'd6: r = 32'd10679838;
			5'd7: r = 32'd5340245;
			5'd8: r = 32'd2670163;
			5'd9: r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			5'd24: r = 32'd41;
			5'd25: r = 32'd20;
			5'd26: r = 32'd10;
			5'd27: r = 32'd5;
			5'd28: r = 32'd3;
			5'd29: r = 32'd1;
			5'd30: r = 32'd1;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

>>> hdl/qot_front.sv
`timescale 1ns / 1ps
module qot_front import qot_pkg::*; #(
	parameter int COUNT_BITS = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      fire,
	input  logic      la,
	input  logic      lb,
	input  logic      ra,
	input  logic      rb,
	input  logic      tick,
	output qot_item_t item
);

	logic                  sampled_q, lla_q, lra_q;
	logic [COUNT_BITS-1:0] lcnt_q, rcnt_q, ltick_q, rtick_q;
	logic [COUNT_BITS-1:0] lnext, rnext, dl, dr;

	// step each counter on a change of A
	always_comb begin
		lnext = lcnt_q;
		rnext = rcnt_q;
		if (sampled_q && la != lla_q) lnext = (la == lb) ? lcnt_q + 1'b1 : lcnt_q - 1'b1;
		if (sampled_q && ra != lra_q) rnext = (ra == rb) ? rcnt_q + 1'b1 : rcnt_q - 1'b1;
		dl = lnext - ltick_q;
		dr = rnext - rtick_q;
	end

	always_comb begin
		item.tick = tick;
		item.dl = 32'(signed'(dl));
		item.dr = 32'(signed'(dr));
		item.lc = 32'(signed'(lnext));
		item.rc = 32'(signed'(rnext));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampled_q <= 1'b0;
			lla_q <= 1'b0;
			lra_q <= 1'b0;
			lcnt_q <= '0;
			rcnt_q <= '0;
			ltick_q <= '0;
			rtick_q <= '0;
		end else if (fire) begin
			sampled_q <= 1'b1;
			lla_q <= la;
			lra_q <= ra;
			lcnt_q <= lnext;
			rcnt_q <= rnext;
			if (tick) begin
				ltick_q <= lnext;
				rtick_q <= rnext;
			end
		end
	end

endmodule

>>> hdl/qot_queue.sv
`timescale 1ns / 1ps
module qot_queue import qot_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  qot_item_t din,
	output logic      full,
	output logic      nonempty,
	input  logic      pop,
	output qot_item_t dout
);

	qot_item_t mem_q [2];
	logic      wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign nonempty = cnt_q != 2'd0;
	assign dout = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !pop |-> !push) else $error("queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("queue underflow");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("queue count");
`endif

endmodule

>>> hdl/qot_back.sv
`timescale 1ns / 1ps
module qot_back import qot_pkg::*; #(
	parameter int CORDIC_STEPS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        avail,
	input  qot_item_t   item,
	output logic        pop,
	input  logic [31:0] mpc,
	input  logic [31:0] apc,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] px,
	output logic [31:0] py,
	output logic [31:0] hd,
	output logic [31:0] lc,
	output logic [31:0] rc,
	output logic        upd
);

	localparam int SW = $clog2(CORDIC_STEPS + 1);

	bk_state_t st_q, st_d;
	logic [31:0] x_q, y_q, h_q, oh_q;
	logic [63:0] tl_q, tr_q;
	logic signed [33:0] cx_q, cy_q, cz_q;
	logic        flip_q;
	logic [SW-1:0] i_q;
	qot_item_t   it_q;
	logic signed [31:0] mean, mean_q;
	logic signed [33:0] xs, ys;
	logic [31:0] at;
	logic signed [33:0] z0;
	logic signed [32:0] dd;
	logic signed [63:0] mx, my;
	logic signed [48:0] sum;
	logic        load;

	assign load = (st_q == BK_IDLE) && avail && !(out_valid && out_stall);
	assign pop = load;

	// mean travel, floored and saturated
	always_comb begin
		sum = 49'(signed'(tl_q[63:16])) + 49'(signed'(tr_q[63:16]));
		sum = sum >>> 1;
		if (sum > 49'sd2147483647) mean = 32'h7fffffff;
		else if (sum < -49'sd2147483648) mean = 32'h80000000;
		else mean = sum[31:0];
		xs = cx_q >>> i_q;
		ys = cy_q >>> i_q;
		at = atan_lut(5'(i_q));
		z0 = 34'(signed'(h_q));
		dd = 33'(signed'(it_q.dl)) - 33'(signed'(it_q.dr));
		mx = 64'(mean_q) * 64'(flip_q ? -cx_q : cx_q);
		my = 64'(mean_q) * 64'(flip_q ? -cy_q : cy_q);
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			BK_IDLE: if (load) st_d = avail && item.tick ? BK_PREP : BK_DONE;
			BK_PREP: st_d = BK_ROT;
			BK_ROT:  if (i_q == SW'(CORDIC_STEPS)) st_d = BK_DONE;
			BK_DONE: st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_d;
	end

	// run the rotation and publish results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= '0; y_q <= '0; h_q <= '0; oh_q <= '0;
			tl_q <= '0; tr_q <= '0;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			flip_q <= 1'b0;
			i_q <= '0;
			it_q <= '0;
			mean_q <= '0;
			px <= '0; py <= '0; hd <= '0;
			lc <= '0; rc <= '0; upd <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && !out_stall) out_valid <= 1'b0;
			unique case (st_q)
				BK_IDLE: if (load) begin
					it_q <= item;
					oh_q <= h_q;
				end
				BK_PREP: begin
					tl_q <= 64'(signed'(it_q.dl)) * 64'(mpc);
					tr_q <= 64'(signed'(it_q.dr)) * 64'(mpc);
					cx_q <= 34'(CORDIC_GAIN);
					cy_q <= '0;
					i_q <= '0;
					if (z0 > 34'sd1073741824) begin
						cz_q <= z0 - 34'sd2147483648; flip_q <= 1'b1;
					end else if (z0 < -34'sd1073741824) begin
						cz_q <= z0 + 34'sd2147483648; flip_q <= 1'b1;
					end else begin
						cz_q <= z0; flip_q <= 1'b0;
					end
				end
				BK_ROT: if (i_q != SW'(CORDIC_STEPS)) begin
					// register the mean while the rotation runs
					mean_q <= mean;
					i_q <= i_q + 1'b1;
					if (cz_q >= 0) begin
						cx_q <= cx_q - ys; cy_q <= cy_q + xs;
						cz_q <= cz_q - 34'(at);
					end else begin
						cx_q <= cx_q + ys; cy_q <= cy_q - xs;
						cz_q <= cz_q + 34'(at);
					end
				end else begin
					x_q <= x_q + mx[61:30];
					y_q <= y_q + my[61:30];
					h_q <= h_q + dd[31:0] * apc;
				end
				BK_DONE: begin
					out_valid <= 1'b1;
					px <= x_q; py <= y_q; hd <= h_q;
					lc <= it_q.lc; rc <= it_q.rc;
					upd <= it_q.tick && (px != x_q || py != y_q || oh_q != h_q);
				end
				default: ;
			endcase
		end
	end

endmodule

>>> hdl/quadrature_odometry_tracker_core.sv
`timescale 1ns / 1ps
// A plain sample passes from the queue through the back end's DONE state; an update tick also
// runs the PREP state and the ROT iterations first. The back end takes one item at a time and
// holds off while the output is stalled; the two-entry queue accepts new samples meanwhile.
// Reset clears counters, pose, heading and restores both registers at once.
module quadrature_odometry_tracker_core import qot_pkg::*; #(
	parameter int CORDIC_STEPS = 24,
	parameter int COUNT_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        left_channel_a,
	input  logic        left_channel_b,
	input  logic        right_channel_a,
	input  logic        right_channel_b,
	input  logic        update_tick,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] position_x,
	output logic [31:0] position_y,
	output logic [31:0] heading_angle,
	output logic [31:0] left_count,
	output logic [31:0] right_count,
	output logic        pose_updated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	logic [31:0] mpc_q, apc_q;
	logic        fire, full, nonempty, pop;
	qot_item_t   fitem, qitem;

	assign in_stall = full;
	assign fire = in_valid && !full;
	assign cfg_ready = 1'b1;

	// hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mpc_q <= MPC_RESET;
			apc_q <= APC_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_MPC) mpc_q <= cfg_data;
			else apc_q <= cfg_data;
		end
	end

	qot_front #(.COUNT_BITS(COUNT_BITS)) u_front (
		.clk, .arst_n, .fire, .la(left_channel_a), .lb(left_channel_b),
		.ra(right_channel_a), .rb(right_channel_b), .tick(update_tick), .item(fitem)
	);

	qot_queue u_queue (
		.clk, .arst_n, .push(fire), .din(fitem), .full, .nonempty, .pop, .dout(qitem)
	);

	qot_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
		.clk, .arst_n, .avail(nonempty), .item(qitem), .pop, .mpc(mpc_q), .apc(apc_q),
		.out_valid, .out_stall, .px(position_x), .py(position_y), .hd(heading_angle),
		.lc(left_count), .rc(right_count), .upd(pose_updated)
	);

endmodule
